/* rtl/dns_query_packet_classifier_defines.svh */
// Assertion macros used by the port-level checker of the DNS query packet classifier.
`ifndef DNS_QUERY_PACKET_CLASSIFIER_DEFINES_SVH
`define DNS_QUERY_PACKET_CLASSIFIER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DQPC_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("dqpc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DQPC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("dqpc assertion failed");

`endif

/* rtl/dqpc_pkg.sv */
// Types and constants of the DNS query packet classifier.
package dqpc_pkg;

    typedef enum logic [3:0] {
        STATUS_QUERY      = 4'd0,
        STATUS_ETH_SHORT  = 4'd1,
        STATUS_NOT_IPV4   = 4'd2,
        STATUS_IP_SHORT   = 4'd3,
        STATUS_NOT_UDP    = 4'd4,
        STATUS_UDP_SHORT  = 4'd5,
        STATUS_WRONG_PORT = 4'd6,
        STATUS_RESPONSE   = 4'd7,
        STATUS_DNS_SHORT  = 4'd8,
        STATUS_BAD_IHL    = 4'd9
    } status_t;

    typedef enum logic [1:0] {
        REG_MATCH_ETHERTYPE = 2'd0,
        REG_MATCH_PROTOCOL  = 2'd1,
        REG_MATCH_PORT      = 2'd2
    } reg_index_t;

    localparam int ETH_LEN          = 14;
    localparam int IP_HDR_MIN_BYTES = 20;
    localparam int UDP_LEN          = 8;
    localparam int DNS_FLAGS_LEN    = 4;
    localparam int IHL_MIN          = 5;
    localparam int ETHERTYPE_HI_POS = 12;
    localparam int ETHERTYPE_LO_POS = 13;
    localparam int IHL_POS          = 14;
    localparam int PROTOCOL_POS     = 23;
    localparam int PORT_POS_BASE    = 16;
    localparam int FLAGS_POS_BASE   = 24;
    localparam int DNS_START_MIN    = ETH_LEN + IP_HDR_MIN_BYTES + UDP_LEN;

    localparam logic [15:0] RESET_ETHERTYPE = 16'h0800;
    localparam logic [7:0]  RESET_PROTOCOL  = 8'd17;
    localparam logic [15:0] RESET_PORT      = 16'd53;

endpackage

/* rtl/dns_query_packet_classifier.sv */
// Top level of the DNS query packet classifier: header capture and frame classification.
//
//   Channel   Direction  Transaction
//   s_*       in         one frame byte (tdata) with the end-of-frame mark (tlast)
//   m_*       out        one result per frame: status and DNS header offset
//   cfg_*     in         register write, no handshake
//
// One byte is accepted per cycle while no final byte waits on a stalled result; the byte goes
// through an input register and the frame state, and on the final byte the result passes
// from the input register into the output register. A stalled result only holds back a final byte behind it.
// Reset clears the frame state and restores the match registers to their defaults.
module dns_query_packet_classifier
    import dqpc_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] status, [10:4] dns_start, [15:11] zero
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [15:0]           match_ethertype_reg;
    logic [7:0]            match_protocol_reg;
    logic [15:0]           match_port_reg;

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    logic                  in_advance;

    logic [COUNT_BITS-1:0] byte_count_reg;
    logic [COUNT_BITS-1:0] byte_count_next;
    logic [15:0]           seen_ethertype_reg;
    logic [15:0]           seen_ethertype_next;
    logic [3:0]            header_words_reg;
    logic [3:0]            header_words_next;
    logic [7:0]            seen_protocol_reg;
    logic [7:0]            seen_protocol_next;
    logic [15:0]           seen_port_reg;
    logic [15:0]           seen_port_next;
    logic                  response_bit_reg;
    logic                  response_bit_next;

    logic [6:0]            port_pos;
    logic [6:0]            flag_pos;
    logic [6:0]            dns_off;
    logic [6:0]            flags_end;
    status_t               status_next;

    logic                  out_valid_reg;
    status_t               status_reg;
    logic [6:0]            dns_start_reg;

    assign in_advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready   = !in_valid_reg || in_advance;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {5'b0, dns_start_reg, status_reg};

    always_comb
    begin
        seen_ethertype_next = seen_ethertype_reg;
        header_words_next   = header_words_reg;
        seen_protocol_next  = seen_protocol_reg;
        seen_port_next      = seen_port_reg;
        response_bit_next   = response_bit_reg;

        port_pos = 7'(PORT_POS_BASE) + {1'b0, header_words_reg, 2'b00};
        flag_pos = 7'(FLAGS_POS_BASE) + {1'b0, header_words_reg, 2'b00};

        if (byte_count_reg == COUNT_BITS'(ETHERTYPE_HI_POS))
        begin
            seen_ethertype_next[15:8] = in_byte_reg;
        end
        if (byte_count_reg == COUNT_BITS'(ETHERTYPE_LO_POS))
        begin
            seen_ethertype_next[7:0] = in_byte_reg;
        end
        if (byte_count_reg == COUNT_BITS'(IHL_POS))
        begin
            header_words_next = in_byte_reg[3:0];
        end
        if (byte_count_reg == COUNT_BITS'(PROTOCOL_POS))
        begin
            seen_protocol_next = in_byte_reg;
        end
        if (byte_count_reg == COUNT_BITS'(port_pos))
        begin
            seen_port_next[15:8] = in_byte_reg;
        end
        if (byte_count_reg == COUNT_BITS'(port_pos + 7'd1))
        begin
            seen_port_next[7:0] = in_byte_reg;
        end
        if (byte_count_reg == COUNT_BITS'(flag_pos))
        begin
            response_bit_next = in_byte_reg[7];
        end

        if (byte_count_reg != COUNT_MAX)
        begin
            byte_count_next = byte_count_reg + COUNT_BITS'(1);
        end
        else
        begin
            byte_count_next = byte_count_reg;
        end

        dns_off   = 7'(ETH_LEN + UDP_LEN) + {1'b0, header_words_next, 2'b00};
        flags_end = dns_off + 7'(DNS_FLAGS_LEN);

        if (byte_count_next < COUNT_BITS'(ETH_LEN))
        begin
            status_next = STATUS_ETH_SHORT;
        end
        else if (seen_ethertype_next != match_ethertype_reg)
        begin
            status_next = STATUS_NOT_IPV4;
        end
        else if (byte_count_next < COUNT_BITS'(ETH_LEN + IP_HDR_MIN_BYTES))
        begin
            status_next = STATUS_IP_SHORT;
        end
        else if (seen_protocol_next != match_protocol_reg)
        begin
            status_next = STATUS_NOT_UDP;
        end
        else if (header_words_next < 4'(IHL_MIN))
        begin
            status_next = STATUS_BAD_IHL;
        end
        else if (byte_count_next < COUNT_BITS'(dns_off))
        begin
            status_next = STATUS_UDP_SHORT;
        end
        else if (seen_port_next != match_port_reg)
        begin
            status_next = STATUS_WRONG_PORT;
        end
        else if (byte_count_next < COUNT_BITS'(flags_end))
        begin
            status_next = STATUS_DNS_SHORT;
        end
        else if (response_bit_next)
        begin
            status_next = STATUS_RESPONSE;
        end
        else
        begin
            status_next = STATUS_QUERY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_ethertype_reg <= RESET_ETHERTYPE;
            match_protocol_reg  <= RESET_PROTOCOL;
            match_port_reg      <= RESET_PORT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MATCH_ETHERTYPE: match_ethertype_reg <= cfg_data;
                REG_MATCH_PROTOCOL:  match_protocol_reg  <= cfg_data[7:0];
                REG_MATCH_PORT:      match_port_reg      <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            byte_count_reg     <= '0;
            seen_ethertype_reg <= '0;
            header_words_reg   <= '0;
            seen_protocol_reg  <= '0;
            seen_port_reg      <= '0;
            response_bit_reg   <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end

            if (in_advance)
            begin
                if (in_last_reg)
                begin
                    byte_count_reg     <= '0;
                    seen_ethertype_reg <= '0;
                    header_words_reg   <= '0;
                    seen_protocol_reg  <= '0;
                    seen_port_reg      <= '0;
                    response_bit_reg   <= 1'b0;
                end
                else
                begin
                    byte_count_reg     <= byte_count_next;
                    seen_ethertype_reg <= seen_ethertype_next;
                    header_words_reg   <= header_words_next;
                    seen_protocol_reg  <= seen_protocol_next;
                    seen_port_reg      <= seen_port_next;
                    response_bit_reg   <= response_bit_next;
                end
            end

            if (in_advance && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (in_advance && in_last_reg)
        begin
            status_reg <= status_next;
            if (status_next == STATUS_QUERY)
            begin
                dns_start_reg <= dns_off;
            end
            else
            begin
                dns_start_reg <= '0;
            end
        end
    end

endmodule

/* rtl/dqpc_checker.sv */
// Port-level assertions of the DNS query packet classifier and their binding.
`include "dns_query_packet_classifier_defines.svh"

module dqpc_checker
    import dqpc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A result that is not taken stays on the bus unchanged.
    `DQPC_ASSERT_NEXT(a_result_holds, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Only the defined status codes are ever reported.
    `DQPC_ASSERT_SAME(a_status_known, clk, rst_n, m_tvalid, m_tdata[3:0] <= STATUS_BAD_IHL)

    // Rejected frames carry no DNS offset.
    `DQPC_ASSERT_SAME(a_offset_zero, clk, rst_n, m_tvalid && m_tdata[3:0] != STATUS_QUERY, m_tdata[10:4] == 7'd0)

    // A query offset covers at least the minimal headers and sits two bytes past a word.
    `DQPC_ASSERT_SAME(a_offset_shape, clk, rst_n, m_tvalid && m_tdata[3:0] == STATUS_QUERY, m_tdata[10:4] >= 7'(DNS_START_MIN) && m_tdata[5:4] == 2'd2)

endmodule

bind dns_query_packet_classifier dqpc_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/dqpc_result_checker.sv */
// Checker that predicts the classifier's per-frame results and compares them with the output.
module dqpc_result_checker
    import dqpc_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          outstanding,
    output logic [9:0]  statuses_seen
);

    typedef struct packed {
        status_t    status;
        logic [6:0] dns_start;
    } frame_verdict_t;

    logic [15:0]           want_ethertype;
    logic [7:0]            want_protocol;
    logic [15:0]           want_port;

    logic [COUNT_BITS-1:0] frame_len;
    logic [15:0]           got_ethertype;
    logic [3:0]            header_words;
    logic [7:0]            got_protocol;
    logic [15:0]           got_port;
    logic                  response_bit;

    frame_verdict_t        verdict_q[$];
    frame_verdict_t        oldest;
    int                    mismatches;
    logic [9:0]            hit_mask;

    function automatic status_t classify_frame(input longint len, input longint dns_off);
        if (len < ETH_LEN) return STATUS_ETH_SHORT;
        if (got_ethertype != want_ethertype) return STATUS_NOT_IPV4;
        if (len < ETH_LEN + IP_HDR_MIN_BYTES) return STATUS_IP_SHORT;
        if (got_protocol != want_protocol) return STATUS_NOT_UDP;
        if (header_words < IHL_MIN) return STATUS_BAD_IHL;
        if (len < dns_off) return STATUS_UDP_SHORT;
        if (got_port != want_port) return STATUS_WRONG_PORT;
        if (len < dns_off + DNS_FLAGS_LEN) return STATUS_DNS_SHORT;
        if (response_bit) return STATUS_RESPONSE;
        return STATUS_QUERY;
    endfunction

    task automatic clear_frame();
        frame_len = '0;
        got_ethertype = '0;
        header_words = '0;
        got_protocol = '0;
        got_port = '0;
        response_bit = 1'b0;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic is_last);
        longint         pos;
        longint         port_pos;
        longint         flags_pos;
        longint         dns_off;
        frame_verdict_t v;
        pos = frame_len;
        port_pos = PORT_POS_BASE + 4 * header_words;
        flags_pos = FLAGS_POS_BASE + 4 * header_words;
        if (pos == ETHERTYPE_HI_POS) got_ethertype[15:8] = b;
        if (pos == ETHERTYPE_LO_POS) got_ethertype[7:0] = b;
        if (pos == IHL_POS) header_words = b[3:0];
        if (pos == PROTOCOL_POS) got_protocol = b;
        if (pos == port_pos) got_port[15:8] = b;
        if (pos == port_pos + 1) got_port[7:0] = b;
        if (pos == flags_pos) response_bit = b[7];
        if (frame_len != '1) frame_len = frame_len + COUNT_BITS'(1);
        if (is_last)
        begin
            dns_off = ETH_LEN + 4 * header_words + UDP_LEN;
            v.status = classify_frame(frame_len, dns_off);
            v.dns_start = (v.status == STATUS_QUERY) ? 7'(dns_off) : 7'd0;
            verdict_q.push_back(v);
            clear_frame();
        end
    endtask

    task automatic report(input string what, input int wanted, input int seen);
        if (mismatches < 10)
            $display("%0t: result error, %s: expected %0d, got %0d", $realtime, what, wanted, seen);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_ethertype = RESET_ETHERTYPE;
            want_protocol = RESET_PROTOCOL;
            want_port = RESET_PORT;
            clear_frame();
            verdict_q.delete();
            mismatches = 0;
            hit_mask = '0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                    report("result with no frame pending", -1, int'(m_tdata[3:0]));
                else
                begin
                    oldest = verdict_q.pop_front();
                    hit_mask[oldest.status] = 1'b1;
                    if (m_tdata[3:0] !== oldest.status)
                        report("status", int'(oldest.status), int'(m_tdata[3:0]));
                    if (m_tdata[10:4] !== oldest.dns_start)
                        report("DNS start", int'(oldest.dns_start), int'(m_tdata[10:4]));
                end
            end
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata, s_tlast);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MATCH_ETHERTYPE: want_ethertype = cfg_data;
                    REG_MATCH_PROTOCOL:  want_protocol = cfg_data[7:0];
                    REG_MATCH_PORT:      want_port = cfg_data;
                    default: ;
                endcase
            end
        end
        fail_count <= mismatches;
        outstanding <= verdict_q.size();
        statuses_seen <= hit_mask;
    end

endmodule

/* tb/tb.sv */
// Testbench top for the DNS query packet classifier: stimulus, idling and verdict.
module tb;
    import dqpc_pkg::*;

    localparam int         COUNT_BITS      = 7;
    localparam int         CLK_HALF        = 2;
    localparam int         RESET_CYCLES    = 6;
    localparam int         HOLD_CYCLES     = 400;
    localparam int         BYTES_PER_PHASE = 70;
    localparam int         LONG_FRAME_LEN  = 140;
    localparam logic [1:0] REG_UNUSED      = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int          fail_count;
    int          outstanding;
    logic [9:0]  statuses_seen;

    bit          sender_gaps;
    bit          receiver_gaps;
    bit          hold_wanted;
    logic [15:0] cur_ethertype;
    logic [7:0]  cur_protocol;
    logic [15:0] cur_port;
    logic [7:0]  frame_bytes[$];
    int          frames_sent;
    int          bytes_sent;

    dns_query_packet_classifier #(.COUNT_BITS(COUNT_BITS)) u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    dqpc_result_checker #(.COUNT_BITS(COUNT_BITS)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .outstanding(outstanding), .statuses_seen(statuses_seen)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_wanted)
            begin
                hold_wanted = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (receiver_gaps && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (sender_gaps && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= is_last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frames_sent++;
    endtask

    task automatic place_byte(input int pos, input logic [7:0] v);
        if (pos < frame_bytes.size()) frame_bytes[pos] = v;
    endtask

    // Random bytes with the header fields laid over them unless raw; a mismatching field differs
    // from the current match register in at least one bit.
    task automatic run_frame(input int len, input int ihl, input bit eth_ok, input bit proto_ok,
                             input bit port_ok, input bit qr, input bit raw);
        logic [15:0] eth;
        logic [7:0]  proto;
        logic [15:0] port;
        int          port_at;
        eth = eth_ok ? cur_ethertype : cur_ethertype ^ 16'($urandom_range(1, 65535));
        proto = proto_ok ? cur_protocol : cur_protocol ^ 8'($urandom_range(1, 255));
        port = port_ok ? cur_port : cur_port ^ 16'($urandom_range(1, 65535));
        port_at = PORT_POS_BASE + 4 * ihl;
        frame_bytes.delete();
        for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom));
        if (!raw)
        begin
            place_byte(ETHERTYPE_HI_POS, eth[15:8]);
            place_byte(ETHERTYPE_LO_POS, eth[7:0]);
            place_byte(IHL_POS, {4'($urandom), 4'(ihl)});
            place_byte(PROTOCOL_POS, proto);
            place_byte(port_at, port[15:8]);
            place_byte(port_at + 1, port[7:0]);
            place_byte(FLAGS_POS_BASE + 4 * ihl, {qr, 7'($urandom)});
        end
        send_frame();
    endtask

    task automatic run_fill_frame(input int len, input logic [7:0] value);
        frame_bytes.delete();
        for (int i = 0; i < len; i++) frame_bytes.push_back(value);
        send_frame();
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_matches(input logic [15:0] eth, input logic [15:0] proto,
                               input logic [15:0] port);
        cfg_we <= 1'b1;
        cfg_index <= REG_MATCH_ETHERTYPE;
        cfg_data <= eth;
        @(posedge clk);
        cfg_index <= REG_MATCH_PROTOCOL;
        cfg_data <= proto;
        @(posedge clk);
        cfg_index <= REG_MATCH_PORT;
        cfg_data <= port;
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data <= 16'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_ethertype = eth;
        cur_protocol = proto[7:0];
        cur_port = port;
    endtask

    // Mostly complete frames with random content, mixed at random with truncated frames and raw noise.
    task automatic random_traffic(input int byte_budget, input bit gaps_allowed);
        int start;
        int pick;
        int ihl;
        int need;
        start = bytes_sent;
        while (bytes_sent - start < byte_budget)
        begin
            pick = $urandom_range(0, 99);
            ihl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
            need = ETH_LEN + 4 * ihl + UDP_LEN + DNS_FLAGS_LEN;
            sender_gaps = gaps_allowed && $urandom_range(0, 3) != 0;
            receiver_gaps = gaps_allowed && $urandom_range(0, 3) != 0;
            if (pick < 70)
                run_frame(need + $urandom_range(0, 24), ihl, $urandom_range(0, 9) != 0,
                          $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                          $urandom_range(0, 1), 1'b0);
            else if (pick < 85)
                run_frame($urandom_range(1, need - 1), ihl, 1'b1, 1'b1, 1'b1,
                          $urandom_range(0, 1), 1'b0);
            else
                run_frame($urandom_range(1, 80), ihl, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_MATCH_ETHERTYPE;
        cfg_data <= '0;
        hold_wanted = 1'b0;
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
        cur_ethertype = RESET_ETHERTYPE;
        cur_protocol = RESET_PROTOCOL;
        cur_port = RESET_PORT;
        frames_sent = 0;
        bytes_sent = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_frame(1, 5, 1, 1, 1, 0, 0);
        run_frame(13, 5, 1, 1, 1, 0, 0);
        run_frame(14, 5, 0, 1, 1, 0, 0);
        run_frame(14, 5, 1, 1, 1, 0, 0);
        run_frame(33, 5, 1, 1, 1, 0, 0);
        run_frame(34, 5, 1, 0, 1, 0, 0);
        run_frame(60, 0, 1, 1, 1, 0, 0);
        run_frame(60, 4, 1, 1, 1, 0, 0);
        run_frame(41, 5, 1, 1, 1, 0, 0);
        run_frame(42, 5, 1, 1, 0, 0, 0);
        run_frame(42, 5, 1, 1, 1, 0, 0);
        run_frame(45, 5, 1, 1, 1, 0, 0);
        run_frame(46, 5, 1, 1, 1, 1, 0);
        run_frame(46, 5, 1, 1, 1, 0, 0);
        run_frame(85, 15, 1, 1, 1, 0, 0);
        run_frame(86, 15, 1, 1, 1, 0, 0);
        run_frame(120, 15, 1, 1, 1, 1, 0);
        run_fill_frame(60, 8'h00);
        run_fill_frame(60, 8'hFF);
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        // Long enough for the byte counter to saturate before the end of the frame.
        run_frame(LONG_FRAME_LEN, 5, 1, 1, 1, 0, 0);
        random_traffic(BYTES_PER_PHASE, 1'b1);

        settle();
        set_matches(16'h0000, 16'h0000, 16'h0000);
        random_traffic(BYTES_PER_PHASE, 1'b1);

        settle();
        set_matches(16'hFFFF, 16'hFFFF, 16'hFFFF);
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        hold_wanted = 1'b1;
        for (int k = 0; k < 30; k++)
            run_frame($urandom_range(1, 4), 5, 1, 1, 1, 0, 1);
        random_traffic(BYTES_PER_PHASE, 1'b1);

        settle();
        set_matches(16'($urandom), 16'($urandom), 16'($urandom));
        random_traffic(BYTES_PER_PHASE, 1'b0);

        settle();
        $display("Sent %0d frames (%0d bytes) under four match settings, one frame saturating the count.",
                 frames_sent, bytes_sent);
        $display("Status codes seen, one bit per code from 0 upward: %b", statuses_seen);
        if (fail_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/dqpc_pkg.sv
rtl/dns_query_packet_classifier.sv
rtl/dqpc_checker.sv
tb/dqpc_result_checker.sv
tb/tb.sv
